// File: src/tsi_pkg.sv
// Package for the timestamped sample interpolator.
// Types, sizes, status codes and controller/datapath command structs.
// No dependencies.
`default_nettype none
package tsi_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_FOUND    = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EMPTY    = 3'd4
    } status_code_t;

    typedef enum logic {
        ACT_ADD = 1'b0,
        ACT_GET = 1'b1
    } action_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] value;
    } entry_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_READ,
        OP_SHIFT,
        OP_PUT,
        OP_RIGHT,
        OP_LEFT_RD,
        OP_LEFT_ZERO,
        OP_DIFF,
        OP_MUL,
        OP_DIV_START,
        OP_RES_ZERO,
        OP_RES_EXACT,
        OP_RES_INTERP,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t          op;
        status_code_t st;
    } cmd_t;

    typedef struct packed {
        logic act;
        logic cnt_full;
        logic cnt_zero;
        logic pos_zero;
        logic first;
        logic rd_gt;
        logic rd_eq;
        logic div_busy;
        logic out_busy;
    } dp_status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_RD,
        S_ADD_CMP,
        S_ADD_DONE,
        S_GET_RD,
        S_GET_CMP,
        S_DIFF,
        S_MUL,
        S_DIV_START,
        S_DIV_WAIT,
        S_INTERP,
        S_OUT
    } state_t;

endpackage
`default_nettype wire

// File: src/tsi_if.sv
// Valid/ready channel interfaces for samples in and results out.
// Depends on nothing.
`default_nettype none
interface tsi_sample_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] sample_time;
    logic [31:0] sample_value;

    modport source (output valid, output action, output sample_time,
                    output sample_value, input ready);
    modport sink   (input valid, input action, input sample_time,
                    input sample_value, output ready);
endinterface

interface tsi_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] result_value;
    logic [31:0] result_time;

    modport source (output valid, output status, output result_value,
                    output result_time, input ready);
    modport sink   (input valid, input status, input result_value,
                    input result_time, output ready);
endinterface
`default_nettype wire

// File: src/tsi_div.sv
// Restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on nothing.
`default_nettype none
module tsi_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             busy,
    output logic [31:0]      quotient
);
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [63:0] quo_reg, quo_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [32:0] rem_sh;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, quo_reg[63]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below divisor, so 32 bits hold it
            if (rem_sh >= {1'b0, dsr_reg})
            begin
                rem_next = 32'(rem_sh - {1'b0, dsr_reg});
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[31:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[31:0];
endmodule
`default_nettype wire

// File: src/tsi_dp.sv
// Datapath: sorted sample memory, scan pointers, multiplier, divider, output register.
// Depends on tsi_pkg, tsi_if, tsi_div.
`default_nettype none
module tsi_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  tsi_pkg::cmd_t        cmd,
    output tsi_pkg::dp_status_t  stat,
    tsi_sample_if.sink           samples,
    tsi_result_if.source         results
);
    tsi_pkg::entry_t mem [tsi_pkg::DEPTH];
    tsi_pkg::entry_t rd_reg;
    tsi_pkg::entry_t left_reg, right_reg;

    logic [tsi_pkg::CW-1:0] count_reg, pos_reg;
    logic                   act_reg;
    logic [31:0]            t_reg, v_reg;

    logic        neg_reg;
    logic [31:0] mag_reg, dt_reg, dx_reg;
    logic [63:0] prod_reg;
    logic [32:0] dy;

    logic [2:0]  res_st_reg;
    logic [31:0] res_val_reg, res_time_reg;

    logic        out_valid_reg;
    logic [2:0]  out_st_reg;
    logic [31:0] out_val_reg, out_time_reg;

    logic        we, re;
    logic [tsi_pkg::AW-1:0] waddr, raddr;
    tsi_pkg::entry_t        wdata;

    logic        div_busy;
    logic [31:0] quotient;

    assign raddr = tsi_pkg::AW'(pos_reg - tsi_pkg::CW'(1));
    assign waddr = pos_reg[tsi_pkg::AW-1:0];
    assign re    = (cmd.op == tsi_pkg::OP_READ);
    assign we    = (cmd.op == tsi_pkg::OP_SHIFT) || (cmd.op == tsi_pkg::OP_PUT);
    assign wdata = (cmd.op == tsi_pkg::OP_SHIFT) ? rd_reg : {t_reg, v_reg};

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

    tsi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == tsi_pkg::OP_DIV_START),
        .dividend (prod_reg),
        .divisor  (dx_reg),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign dy = {right_reg.value[31], right_reg.value} - {left_reg.value[31], left_reg.value};

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            act_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                tsi_pkg::OP_LATCH:
                begin
                    act_reg <= samples.action;
                    pos_reg <= count_reg;
                end
                tsi_pkg::OP_SHIFT, tsi_pkg::OP_RIGHT:
                begin
                    pos_reg <= pos_reg - tsi_pkg::CW'(1);
                end
                tsi_pkg::OP_PUT:
                begin
                    count_reg <= count_reg + tsi_pkg::CW'(1);
                end
                default:
                begin
                end
            endcase
            if (cmd.op == tsi_pkg::OP_EMIT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            tsi_pkg::OP_LATCH:
            begin
                t_reg <= samples.sample_time;
                v_reg <= samples.sample_value;
            end
            tsi_pkg::OP_RIGHT:     right_reg <= rd_reg;
            tsi_pkg::OP_LEFT_RD:   left_reg  <= rd_reg;
            tsi_pkg::OP_LEFT_ZERO: left_reg  <= '0;
            tsi_pkg::OP_DIFF:
            begin
                neg_reg <= dy[32];
                mag_reg <= dy[32] ? 32'(-dy) : dy[31:0];
                dt_reg  <= t_reg - left_reg.stamp;
                dx_reg  <= right_reg.stamp - left_reg.stamp;
            end
            tsi_pkg::OP_MUL:
            begin
                prod_reg <= 64'(mag_reg) * 64'(dt_reg);
            end
            tsi_pkg::OP_RES_ZERO:
            begin
                res_st_reg   <= cmd.st;
                res_val_reg  <= '0;
                res_time_reg <= '0;
            end
            tsi_pkg::OP_RES_EXACT:
            begin
                res_st_reg   <= tsi_pkg::ST_FOUND;
                res_val_reg  <= rd_reg.value;
                res_time_reg <= t_reg;
            end
            tsi_pkg::OP_RES_INTERP:
            begin
                res_st_reg   <= tsi_pkg::ST_FOUND;
                res_val_reg  <= neg_reg ? left_reg.value - quotient
                                        : left_reg.value + quotient;
                res_time_reg <= t_reg;
            end
            tsi_pkg::OP_EMIT:
            begin
                out_st_reg   <= res_st_reg;
                out_val_reg  <= res_val_reg;
                out_time_reg <= res_time_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign stat.act      = act_reg;
    assign stat.cnt_full = (count_reg == tsi_pkg::CW'(tsi_pkg::DEPTH));
    assign stat.cnt_zero = (count_reg == '0);
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.first    = (pos_reg == count_reg);
    assign stat.rd_gt    = (rd_reg.stamp > t_reg);
    assign stat.rd_eq    = (rd_reg.stamp == t_reg);
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg && !results.ready;

    assign results.valid        = out_valid_reg;
    assign results.status       = out_st_reg;
    assign results.result_value = out_val_reg;
    assign results.result_time  = out_time_reg;
endmodule
`default_nettype wire

// File: src/tsi_ctrl.sv
// Controller state machine: sequences insert scans, lookups and division.
// Depends on tsi_pkg.
`default_nettype none
module tsi_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  tsi_pkg::dp_status_t stat,
    input  wire logic           in_valid,
    output logic                in_ready,
    output tsi_pkg::cmd_t       cmd
);
    tsi_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tsi_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsi_pkg::S_IDLE:
                if (in_valid) state_next = tsi_pkg::S_DISPATCH;
            tsi_pkg::S_DISPATCH:
                if (stat.act == tsi_pkg::ACT_ADD)
                    state_next = stat.cnt_full ? tsi_pkg::S_OUT : tsi_pkg::S_ADD_RD;
                else
                    state_next = stat.cnt_zero ? tsi_pkg::S_OUT : tsi_pkg::S_GET_RD;
            tsi_pkg::S_ADD_RD:
                state_next = stat.pos_zero ? tsi_pkg::S_ADD_DONE : tsi_pkg::S_ADD_CMP;
            tsi_pkg::S_ADD_CMP:
                state_next = stat.rd_gt ? tsi_pkg::S_ADD_RD : tsi_pkg::S_ADD_DONE;
            tsi_pkg::S_ADD_DONE:
                state_next = tsi_pkg::S_OUT;
            tsi_pkg::S_GET_RD:
                state_next = stat.pos_zero ? tsi_pkg::S_DIFF : tsi_pkg::S_GET_CMP;
            tsi_pkg::S_GET_CMP:
                if (stat.rd_gt)          state_next = tsi_pkg::S_GET_RD;
                else if (stat.first)     state_next = tsi_pkg::S_OUT;
                else                     state_next = tsi_pkg::S_DIFF;
            tsi_pkg::S_DIFF:      state_next = tsi_pkg::S_MUL;
            tsi_pkg::S_MUL:       state_next = tsi_pkg::S_DIV_START;
            tsi_pkg::S_DIV_START: state_next = tsi_pkg::S_DIV_WAIT;
            tsi_pkg::S_DIV_WAIT:
                if (!stat.div_busy) state_next = tsi_pkg::S_INTERP;
            tsi_pkg::S_INTERP:    state_next = tsi_pkg::S_OUT;
            tsi_pkg::S_OUT:
                if (!stat.out_busy) state_next = tsi_pkg::S_IDLE;
            default:              state_next = tsi_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = tsi_pkg::OP_NONE;
        cmd.st   = tsi_pkg::ST_ADDED;
        unique case (state_reg)
            tsi_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = tsi_pkg::OP_LATCH;
            end
            tsi_pkg::S_DISPATCH:
            begin
                if (stat.act == tsi_pkg::ACT_ADD && stat.cnt_full)
                begin
                    cmd.op = tsi_pkg::OP_RES_ZERO;
                    cmd.st = tsi_pkg::ST_FULL;
                end
                else if (stat.act == tsi_pkg::ACT_GET && stat.cnt_zero)
                begin
                    cmd.op = tsi_pkg::OP_RES_ZERO;
                    cmd.st = tsi_pkg::ST_EMPTY;
                end
            end
            tsi_pkg::S_ADD_RD:
                cmd.op = stat.pos_zero ? tsi_pkg::OP_PUT : tsi_pkg::OP_READ;
            tsi_pkg::S_ADD_CMP:
                cmd.op = stat.rd_gt ? tsi_pkg::OP_SHIFT : tsi_pkg::OP_PUT;
            tsi_pkg::S_ADD_DONE:
            begin
                cmd.op = tsi_pkg::OP_RES_ZERO;
                cmd.st = tsi_pkg::ST_ADDED;
            end
            tsi_pkg::S_GET_RD:
                cmd.op = stat.pos_zero ? tsi_pkg::OP_LEFT_ZERO : tsi_pkg::OP_READ;
            tsi_pkg::S_GET_CMP:
            begin
                if (stat.rd_gt)
                begin
                    cmd.op = tsi_pkg::OP_RIGHT;
                end
                else if (stat.first && stat.rd_eq)
                begin
                    cmd.op = tsi_pkg::OP_RES_EXACT;
                end
                else if (stat.first)
                begin
                    cmd.op = tsi_pkg::OP_RES_ZERO;
                    cmd.st = tsi_pkg::ST_NOTFOUND;
                end
                else
                begin
                    cmd.op = tsi_pkg::OP_LEFT_RD;
                end
            end
            tsi_pkg::S_DIFF:      cmd.op = tsi_pkg::OP_DIFF;
            tsi_pkg::S_MUL:       cmd.op = tsi_pkg::OP_MUL;
            tsi_pkg::S_DIV_START: cmd.op = tsi_pkg::OP_DIV_START;
            tsi_pkg::S_DIV_WAIT:  cmd.op = tsi_pkg::OP_NONE;
            tsi_pkg::S_INTERP:    cmd.op = tsi_pkg::OP_RES_INTERP;
            tsi_pkg::S_OUT:
                if (!stat.out_busy) cmd.op = tsi_pkg::OP_EMIT;
            default:              cmd.op = tsi_pkg::OP_NONE;
        endcase
    end
endmodule
`default_nettype wire

// File: src/timestamped_sample_interpolator_unit.sv
// Top level of the timestamped sample interpolator.
// Depends on tsi_pkg, tsi_if, tsi_ctrl, tsi_dp (and tsi_div below it).
//
//   channel   dir  fields
//   samples   in   action, sample_time, sample_value
//   results   out  status, result_value, result_time
//
// One item at a time. An add reads each stored sample with a later timestamp
// and moves it up a slot, then writes the new sample into the freed slot.
// A get scans down past the samples above the query, then waits on the 64/32
// serial divider. A hit or miss on the last sample skips the divider, and full
// and empty skip the scan. Control state resets; memory and payload do not.
// The controller stalls while the divider is busy and while the output register is full.
`default_nettype none
module timestamped_sample_interpolator_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tsi_sample_if.sink   samples,
    tsi_result_if.source results
);
    tsi_pkg::cmd_t       cmd;
    tsi_pkg::dp_status_t stat;
    logic                in_ready;

    // sequencing only; no payload passes through here
    tsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .in_valid (samples.valid),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // memory, arithmetic and output register
    tsi_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .samples (samples),
        .results (results)
    );

    assign samples.ready = in_ready;

`ifndef SYNTHESIS
    // one sample at a time: after a transfer in, input closes
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid && samples.ready |=> !samples.ready)
        else $error("input accepted while busy");

    // add results and misses carry zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid && (results.status == tsi_pkg::ST_ADDED
                       || results.status == tsi_pkg::ST_FULL
                       || results.status == tsi_pkg::ST_NOTFOUND
                       || results.status == tsi_pkg::ST_EMPTY)
        |-> results.result_value == '0 && results.result_time == '0)
        else $error("nonzero payload on non-found result");
`endif
endmodule
`default_nettype wire
